FILE: rtl/mcst_pkg.sv
// Package of shared types, codes and constants for the multi-channel soft timer unit.
package mcst_pkg;

  localparam int unsigned DefaultNumTimers = 16;
  localparam int unsigned FuncW = 3;
  localparam int unsigned IdW = 5;
  localparam int unsigned TimeW = 32;
  localparam int unsigned KindW = 2;
  localparam logic [TimeW-1:0] AllOnes = '1;
  localparam logic [TimeW-1:0] MinOkPeriod = 32'd3;
  localparam logic [TimeW-1:0] ShortPeriod = 32'd2;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK   = 3'd0,
    FUNC_CREATE = 3'd1,
    FUNC_CHANGE = 3'd2,
    FUNC_KILL   = 3'd3,
    FUNC_RESET  = 3'd4,
    FUNC_CALL   = 3'd5
  } func_e;

  typedef enum logic [KindW-1:0] {
    KIND_REPLY   = 2'd0,
    KIND_EXPIRY  = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  // Classified command handed from the front end to the execution engine.
  typedef enum logic [2:0] {
    OP_TICK,
    OP_ARM,
    OP_KILL,
    OP_RESTART,
    OP_CALL,
    OP_FAIL
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] period;
    logic             periodic;
    logic [TimeW-1:0] now;
  } cmd_t;

  typedef struct packed {
    kind_e            kind;
    logic [IdW-1:0]   id;
    logic             status;
    logic [TimeW-1:0] wait_val;
    logic             last;
  } res_t;

endpackage

FILE: rtl/mcst_front.sv
// Front end: accepts commands, picks the target slot and queues classified commands.
module mcst_front #(
  parameter int unsigned NumTimers = mcst_pkg::DefaultNumTimers
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [mcst_pkg::FuncW-1:0]  func_i,
  input  logic [mcst_pkg::IdW-1:0]    timer_id_i,
  input  logic [mcst_pkg::TimeW-1:0]  period_i,
  input  logic                        periodic_i,
  input  logic [mcst_pkg::TimeW-1:0]  now_i,
  input  logic [NumTimers-1:0]        used_i,
  output logic                        cmd_valid_o,
  output mcst_pkg::cmd_t              cmd_o,
  input  logic                        cmd_take_i
);

  localparam int unsigned SlotW = (NumTimers > 1) ? $clog2(NumTimers) : 1;

  // One-entry queue. The used map only changes when the back end executes, and a
  // create is allocated from it here, so only one command may be in flight at a
  // time: a new one is admitted once the back end has taken and applied the last.
  mcst_pkg::cmd_t cmd_q;
  logic           valid_q;
  logic           busy_i_q;
  mcst_pkg::cmd_t cmd_d;
  logic           free_found;
  logic [mcst_pkg::IdW-1:0] free_id;

  always_comb begin
    free_found = 1'b0;
    free_id    = '0;
    for (int s = NumTimers - 1; s >= 0; s--) begin
      if (!used_i[s]) begin
        free_found = 1'b1;
        free_id    = mcst_pkg::IdW'(s + 1);
      end
    end
  end

  always_comb begin
    logic known;
    known = (timer_id_i != '0) && ({1'b0, timer_id_i} <= (mcst_pkg::IdW+1)'(NumTimers));
    if (known) begin
      known = used_i[SlotW'(timer_id_i - 1'b1)];
    end
    cmd_d.id       = timer_id_i;
    cmd_d.period   = (period_i < mcst_pkg::MinOkPeriod) ? mcst_pkg::ShortPeriod : period_i;
    cmd_d.periodic = periodic_i;
    cmd_d.now      = now_i;
    cmd_d.op       = mcst_pkg::OP_FAIL;
    case (func_i)
      mcst_pkg::FUNC_TICK: cmd_d.op = mcst_pkg::OP_TICK;
      mcst_pkg::FUNC_CREATE, mcst_pkg::FUNC_CHANGE: begin
        if (func_i == mcst_pkg::FUNC_CREATE || timer_id_i == '0) begin
          cmd_d.op = free_found ? mcst_pkg::OP_ARM : mcst_pkg::OP_FAIL;
          cmd_d.id = free_id;
        end else if (known) begin
          cmd_d.op = mcst_pkg::OP_ARM;
        end
      end
      mcst_pkg::FUNC_KILL:  if (known) cmd_d.op = mcst_pkg::OP_KILL;
      mcst_pkg::FUNC_RESET: if (known) cmd_d.op = mcst_pkg::OP_RESTART;
      mcst_pkg::FUNC_CALL:  if (known) cmd_d.op = mcst_pkg::OP_CALL;
      default: cmd_d.op = mcst_pkg::OP_FAIL;
    endcase
  end

  assign full_o      = valid_q || busy_i_q;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  // busy_i_q covers the cycle in which the back end applies a taken command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      busy_i_q <= 1'b0;
    end else begin
      busy_i_q <= valid_q && cmd_take_i;
      if (valid_q && cmd_take_i) begin
        valid_q <= 1'b0;
      end else if (push_i && !full_o) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

FILE: rtl/mcst_back.sv
// Back end: executes commands on the timer table and scans it on a tick.
module mcst_back #(
  parameter int unsigned NumTimers = mcst_pkg::DefaultNumTimers
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  mcst_pkg::cmd_t       cmd_i,
  output logic                 cmd_take_o,
  output logic [NumTimers-1:0] used_o,
  output logic                 res_valid_o,
  output mcst_pkg::res_t       res_o,
  input  logic                 res_ready_i
);

  localparam int unsigned SlotW = (NumTimers > 1) ? $clog2(NumTimers) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_WAITRES,
    ST_CALLREP
  } state_e;

  logic [mcst_pkg::TimeW-1:0] period_mem [NumTimers];
  logic [mcst_pkg::TimeW-1:0] start_mem  [NumTimers];
  logic [NumTimers-1:0] used_q, running_q, oneshot_q, repeat_q, saved_q;

  state_e                     state_q;
  mcst_pkg::cmd_t             cmd_q;
  logic [SlotW-1:0]           slot_q;
  logic [mcst_pkg::TimeW-1:0] rd_period_q, rd_start_q;
  logic [mcst_pkg::TimeW-1:0] wait_q;
  logic                       due_q;
  logic                       res_valid_q;
  mcst_pkg::res_t             res_q;
  logic                       last_slot;

  assign used_o      = used_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign cmd_take_o  = (state_q == ST_IDLE) && cmd_valid_i && !res_valid_q;
  assign last_slot   = ({1'b0, slot_q} == (SlotW+1)'(NumTimers - 1));

  // Memory read port, registered.
  always_ff @(posedge clk_i) begin
    rd_period_q <= period_mem[slot_q];
    rd_start_q  <= start_mem[slot_q];
  end

  // Evaluation of the slot read in the previous cycle.
  logic [mcst_pkg::TimeW-1:0] elapsed, remain;
  logic                       expired;
  assign elapsed = cmd_q.now - rd_start_q;
  assign expired = elapsed >= rd_period_q;
  assign remain  = rd_period_q - elapsed;

  logic [SlotW-1:0] cmd_slot;
  assign cmd_slot = SlotW'(cmd_i.id - 1'b1);

  always_ff @(posedge clk_i) begin
    if (cmd_take_o && cmd_i.op == mcst_pkg::OP_ARM) begin
      period_mem[cmd_slot] <= cmd_i.period;
      start_mem[cmd_slot]  <= cmd_i.now;
    end else if (cmd_take_o && cmd_i.op == mcst_pkg::OP_RESTART) begin
      start_mem[cmd_slot]  <= cmd_i.now;
    end else if (state_q == ST_EVAL && used_q[slot_q] && expired && repeat_q[slot_q]) begin
      start_mem[slot_q] <= rd_start_q + rd_period_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      running_q   <= '0;
      oneshot_q   <= '0;
      repeat_q    <= '0;
      saved_q     <= '0;
      res_valid_q <= 1'b0;
      slot_q      <= '0;
      due_q       <= 1'b0;
      wait_q      <= '0;
      cmd_q       <= '0;
      res_q       <= '0;
    end else begin
      if (res_valid_q && res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_take_o) begin
            cmd_q       <= cmd_i;
            res_q.kind  <= mcst_pkg::KIND_REPLY;
            res_q.id    <= cmd_i.id;
            res_q.status <= 1'b0;
            res_q.wait_val <= '0;
            res_q.last  <= 1'b1;
            case (cmd_i.op)
              mcst_pkg::OP_TICK: begin
                slot_q  <= '0;
                wait_q  <= mcst_pkg::AllOnes;
                due_q   <= 1'b0;
                state_q <= ST_READ;
              end
              mcst_pkg::OP_ARM: begin
                used_q[cmd_slot]    <= 1'b1;
                running_q[cmd_slot] <= 1'b1;
                oneshot_q[cmd_slot] <= !cmd_i.periodic;
                repeat_q[cmd_slot]  <= cmd_i.periodic;
                saved_q[cmd_slot]   <= cmd_i.periodic;
                res_valid_q <= 1'b1;
              end
              mcst_pkg::OP_KILL: begin
                running_q[cmd_slot] <= 1'b0;
                oneshot_q[cmd_slot] <= 1'b0;
                repeat_q[cmd_slot]  <= 1'b0;
                res_valid_q <= 1'b1;
              end
              mcst_pkg::OP_RESTART: begin
                running_q[cmd_slot] <= 1'b1;
                oneshot_q[cmd_slot] <= !saved_q[cmd_slot];
                repeat_q[cmd_slot]  <= saved_q[cmd_slot];
                res_valid_q <= 1'b1;
              end
              mcst_pkg::OP_CALL: begin
                if (running_q[cmd_slot]) begin
                  res_q.kind <= mcst_pkg::KIND_EXPIRY;
                  res_q.last <= 1'b0;
                  state_q    <= ST_CALLREP;
                end
                res_valid_q <= 1'b1;
              end
              default: begin
                res_q.id     <= '0;
                res_q.status <= 1'b1;
                res_valid_q  <= 1'b1;
              end
            endcase
          end
        end
        ST_CALLREP: begin
          if (!res_valid_q || res_ready_i) begin
            res_q.kind  <= mcst_pkg::KIND_REPLY;
            res_q.last  <= 1'b1;
            res_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_READ: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          // The model's fire pass and wait pass touch each slot independently,
          // so both are folded into one visit per slot.
          if (used_q[slot_q]) begin
            if (expired && (repeat_q[slot_q] || oneshot_q[slot_q])) begin
              res_q.kind     <= mcst_pkg::KIND_EXPIRY;
              res_q.id       <= mcst_pkg::IdW'({1'b0, slot_q} + 1'b1);
              res_q.status   <= 1'b0;
              res_q.wait_val <= '0;
              res_q.last     <= 1'b0;
              res_valid_q    <= 1'b1;
            end
            if (expired && oneshot_q[slot_q]) begin
              running_q[slot_q] <= 1'b0;
              oneshot_q[slot_q] <= 1'b0;
            end else if (running_q[slot_q]) begin
              if (expired && !repeat_q[slot_q]) begin
                due_q <= 1'b1;
              end else begin
                logic [mcst_pkg::TimeW-1:0] r;
                logic [mcst_pkg::TimeW-1:0] el2;
                el2 = expired ? (elapsed - rd_period_q) : elapsed;
                r   = expired ? (rd_period_q - el2) : remain;
                if (expired && el2 >= rd_period_q) begin
                  due_q <= 1'b1;
                end else if (r < wait_q) begin
                  wait_q <= r;
                end
              end
            end
          end
          state_q <= ST_WAITRES;
        end
        ST_WAITRES: begin
          if (!res_valid_q || res_ready_i) begin
            if (last_slot) begin
              res_q.kind     <= mcst_pkg::KIND_SUMMARY;
              res_q.id       <= '0;
              res_q.status   <= 1'b0;
              res_q.wait_val <= due_q ? '0 : wait_q;
              res_q.last     <= 1'b1;
              res_valid_q    <= 1'b1;
              state_q        <= ST_IDLE;
            end else begin
              slot_q  <= slot_q + 1'b1;
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/multi_channel_soft_timer_unit.sv
// Top level of the multi-channel soft timer unit.
// The unit holds NumTimers periodic or one-shot timer channels. Each command
// transaction pushed on the input queue carries a function code, a timer id,
// a period, a mode flag and the current free-running time.
// The input side is a queue: a transaction is taken when push is high and
// full is low. Results leave through a queue as well: the oldest result is
// on the ports while empty is low and is taken when pop is high.
// A front end classifies each command and picks the free slot for a create;
// a back end applies it to the timer table and scans the table on a tick.
// A non-tick command waits in the front queue until the back end is idle with
// no result pending; its first result is registered as it is taken, and the
// next command is accepted only once the previous one has been applied.
// A tick visits every slot in turn through the read, eval and wait states,
// as the period and start memories have a single read port; every expired
// running timer yields one expiry result and a summary result with the
// shortest remaining wait closes the tick.
// If the receiver stalls, the result register holds and the scan pauses.
// Reset empties the table: no timer is in use and both queues are empty.
module multi_channel_soft_timer_unit #(
  parameter int unsigned NumTimers = mcst_pkg::DefaultNumTimers
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [mcst_pkg::FuncW-1:0]   func_i,
  input  logic [mcst_pkg::IdW-1:0]     timer_id_i,
  input  logic [mcst_pkg::TimeW-1:0]   period_i,
  input  logic                         periodic_i,
  input  logic [mcst_pkg::TimeW-1:0]   now_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [mcst_pkg::KindW-1:0]   result_kind_o,
  output logic [mcst_pkg::IdW-1:0]     reply_id_o,
  output logic                         status_o,
  output logic [mcst_pkg::TimeW-1:0]   next_wait_o,
  output logic                         last_o
);

  logic                 cmd_valid, cmd_take, res_valid;
  mcst_pkg::cmd_t       cmd;
  mcst_pkg::res_t       res;
  logic [NumTimers-1:0] used;

  mcst_front #(.NumTimers(NumTimers)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .func_i, .timer_id_i, .period_i, .periodic_i, .now_i,
    .used_i(used), .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  mcst_back #(.NumTimers(NumTimers)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .used_o(used), .res_valid_o(res_valid), .res_o(res), .res_ready_i(pop)
  );

  assign empty         = !res_valid;
  assign result_kind_o = res.kind;
  assign reply_id_o    = res.id;
  assign status_o      = res.status;
  assign next_wait_o   = res.wait_val;
  assign last_o        = res.last;

  // A failed reply never names a timer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> (reply_id_o == '0))
    else $error("failed reply carries a timer id");

  // Only a summary carries a wait value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o != mcst_pkg::KIND_SUMMARY) |-> (next_wait_o == '0))
    else $error("wait value outside a summary");

  // A summary always ends its transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o == mcst_pkg::KIND_SUMMARY) |-> last_o)
    else $error("summary not marked last");

endmodule
